// File: hw/rtl/per_user_token_bucket_limiter_assert.svh
// Assertion macros for the per-user token bucket limiter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef PER_USER_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define PER_USER_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define PTBL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTBL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ptbl_pkg.sv
// Shared constants, stage structs and CSR codes for the token bucket limiter.
// No dependencies; imported by every RTL module of the block.
package ptbl_pkg;

   localparam int USER_COUNT       = 64;
   localparam int TICKS_PER_SECOND = 1000;

   localparam int USER_W  = 6;
   localparam int TICKS_W = 32;
   localparam int TOKEN_W = 16;
   localparam int RATE_W  = 16;
   localparam int MEM_AW  = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;

   // floor(n / TICKS_PER_SECOND) == (n * DIV_MUL) >> DIV_SHIFT for any 32-bit n
   localparam int DIV_SHIFT = TICKS_W + $clog2(TICKS_PER_SECOND);
   localparam int DIV_MUL_W = TICKS_W + 1;
   localparam int DIV_PROD_W = TICKS_W + DIV_MUL_W;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(
      ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));

   // refill amounts are clamped here; anything this large fills any bucket
   localparam int ADD_W = TOKEN_W + 1;
   localparam logic [ADD_W-1:0] ADD_SAT = ADD_W'(1) << TOKEN_W;
   localparam int REFILL_PROD_W = ADD_W + RATE_W;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL   = 8'd1;

   localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 16'd5;
   localparam logic [RATE_W-1:0]  REFILL_RESET   = 16'd1;

   typedef struct packed {
      logic               vld;
      logic [USER_W-1:0]  user;
      logic               in_range;
      logic               is_new;
      logic               refill;
      logic [TICKS_W-1:0] elapsed;
   } elap_type;

   typedef struct packed {
      logic               vld;
      logic [USER_W-1:0]  user;
      logic               in_range;
      logic               is_new;
      logic               refill;
      logic [TICKS_W-1:0] secs;
   } secs_type;

   typedef struct packed {
      logic              vld;
      logic [USER_W-1:0] user;
      logic              in_range;
      logic              is_new;
      logic              refill;
      logic [ADD_W-1:0]  add_amt;
   } add_type;

endpackage

// File: hw/rtl/ptbl_time.sv
// Front stage: entry valid bits, last-refill time memory and elapsed-time calc.
// Depends on ptbl_pkg.
module ptbl_time import ptbl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               req_valid,
   input  logic [USER_W-1:0]  req_user_index,
   input  logic [TICKS_W-1:0] req_now_ticks,
   output elap_type           elap_o
);

   logic [TICKS_W-1:0]    last_mem [USER_COUNT];
   logic [TICKS_W-1:0]    last_rd_ff;
   logic                  byp_hit_ff;
   logic [TICKS_W-1:0]    byp_data_ff;
   logic [USER_COUNT-1:0] exists_ff;

   logic                  s1_vld_ff;
   logic [USER_W-1:0]     s1_user_ff;
   logic [TICKS_W-1:0]    s1_now_ff;
   logic                  s1_in_range_ff;

   logic                  elap_vld_ff;
   elap_type              elap_ff;

   logic [MEM_AW-1:0]     req_addr;
   logic [MEM_AW-1:0]     s1_addr;
   logic                  req_in_range;
   logic                  is_new;
   logic [TICKS_W-1:0]    last_eff;
   logic [TICKS_W-1:0]    elapsed;
   logic                  refill;
   logic [TICKS_W-1:0]    last_wr_in;
   logic                  s1_wr;

   assign req_addr     = MEM_AW'(req_user_index);
   assign s1_addr      = MEM_AW'(s1_user_ff);
   assign req_in_range = 32'(req_user_index) < USER_COUNT;

   assign is_new     = !exists_ff[s1_addr];
   // the memory read misses a write landing on the same edge; bypass covers it
   assign last_eff   = is_new     ? s1_now_ff   :
                       byp_hit_ff ? byp_data_ff : last_rd_ff;
   assign elapsed    = s1_now_ff - last_eff;
   assign refill     = elapsed >= TICKS_W'(TICKS_PER_SECOND);
   assign last_wr_in = refill ? s1_now_ff : last_eff;
   assign s1_wr      = adv && s1_vld_ff && s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         last_rd_ff     <= last_mem[req_addr];
         byp_hit_ff     <= s1_wr && (s1_user_ff == req_user_index);
         byp_data_ff    <= last_wr_in;
         s1_user_ff     <= req_user_index;
         s1_now_ff      <= req_now_ticks;
         s1_in_range_ff <= req_in_range;
         elap_ff.vld      <= 1'b0;
         elap_ff.user     <= s1_user_ff;
         elap_ff.in_range <= s1_in_range_ff;
         elap_ff.is_new   <= is_new;
         elap_ff.refill   <= refill;
         elap_ff.elapsed  <= elapsed;
      end
      if (s1_wr) begin
         last_mem[s1_addr] <= last_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         elap_vld_ff <= 1'b0;
         exists_ff   <= '0;
      end else begin
         if (adv) begin
            s1_vld_ff   <= req_valid;
            elap_vld_ff <= s1_vld_ff;
         end
         if (s1_wr) begin
            exists_ff[s1_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      elap_o     = elap_ff;
      elap_o.vld = elap_vld_ff;
   end

endmodule

// File: hw/rtl/ptbl_scale.sv
// Middle stages: whole seconds by reciprocal multiply, then seconds times rate.
// Depends on ptbl_pkg.
module ptbl_scale import ptbl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [RATE_W-1:0] rate,
   input  elap_type          elap_i,
   output secs_type          secs_o,
   output add_type           add_o
);

   secs_type                 secs_ff;
   logic                     secs_vld_ff;
   add_type                  add_ff;
   logic                     add_vld_ff;

   logic [DIV_PROD_W-1:0]    div_prod;
   logic [TICKS_W-1:0]       secs;
   logic [ADD_W-1:0]         secs_sat;
   logic [REFILL_PROD_W-1:0] refill_prod;
   logic [ADD_W-1:0]         add_amt;

   assign div_prod = {{DIV_MUL_W{1'b0}}, elap_i.elapsed} *
                     {{TICKS_W{1'b0}}, DIV_MUL};
   assign secs     = TICKS_W'(div_prod >> DIV_SHIFT);

   // past 2^16 seconds any nonzero rate fills the bucket anyway
   assign secs_sat    = (secs_ff.secs >= TICKS_W'(ADD_SAT)) ? ADD_SAT :
                        ADD_W'(secs_ff.secs);
   assign refill_prod = {{RATE_W{1'b0}}, secs_sat} * {{ADD_W{1'b0}}, rate};
   assign add_amt     = (refill_prod >= REFILL_PROD_W'(ADD_SAT)) ? ADD_SAT :
                        ADD_W'(refill_prod);

   always_ff @(posedge clock) begin
      if (adv) begin
         secs_ff.vld      <= 1'b0;
         secs_ff.user     <= elap_i.user;
         secs_ff.in_range <= elap_i.in_range;
         secs_ff.is_new   <= elap_i.is_new;
         secs_ff.refill   <= elap_i.refill;
         secs_ff.secs     <= secs;
         add_ff.vld       <= 1'b0;
         add_ff.user      <= secs_ff.user;
         add_ff.in_range  <= secs_ff.in_range;
         add_ff.is_new    <= secs_ff.is_new;
         add_ff.refill    <= secs_ff.refill;
         add_ff.add_amt   <= add_amt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         secs_vld_ff <= 1'b0;
         add_vld_ff  <= 1'b0;
      end else if (adv) begin
         secs_vld_ff <= elap_i.vld;
         add_vld_ff  <= secs_vld_ff;
      end
   end

   always_comb begin
      secs_o     = secs_ff;
      secs_o.vld = secs_vld_ff;
      add_o      = add_ff;
      add_o.vld  = add_vld_ff;
   end

endmodule

// File: hw/rtl/ptbl_token.sv
// Last stage: token count memory read-modify-write and the result register.
// Depends on ptbl_pkg.
module ptbl_token import ptbl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [TOKEN_W-1:0] capacity,
   input  secs_type           secs_i,
   input  add_type            add_i,
   output logic               rsp_valid,
   output logic               rsp_allowed
);

   logic [TOKEN_W-1:0] tok_mem [USER_COUNT];
   logic [TOKEN_W-1:0] tok_rd_ff;
   logic               byp_hit_ff;
   logic [TOKEN_W-1:0] byp_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_allowed_ff;

   logic [MEM_AW-1:0]  rd_addr;
   logic [MEM_AW-1:0]  wr_addr;
   logic [TOKEN_W-1:0] tok_base;
   logic [TOKEN_W+1:0] tok_sum;
   logic [TOKEN_W-1:0] tok_capped;
   logic [TOKEN_W-1:0] tok_ref;
   logic               allowed;
   logic [TOKEN_W-1:0] tok_wr_in;
   logic               tok_wr;

   assign rd_addr = MEM_AW'(secs_i.user);
   assign wr_addr = MEM_AW'(add_i.user);

   assign tok_base   = add_i.is_new ? capacity    :
                       byp_hit_ff   ? byp_data_ff : tok_rd_ff;
   assign tok_sum    = {2'b00, tok_base} + {1'b0, add_i.add_amt};
   assign tok_capped = (tok_sum > {2'b00, capacity}) ? capacity : TOKEN_W'(tok_sum);
   // without a whole second elapsed the count is left alone, even above capacity
   assign tok_ref    = add_i.refill ? tok_capped : tok_base;
   assign allowed    = add_i.in_range && (tok_ref != '0);
   assign tok_wr_in  = tok_ref - TOKEN_W'(allowed);
   assign tok_wr     = adv && add_i.vld && add_i.in_range;

   always_ff @(posedge clock) begin
      if (adv) begin
         tok_rd_ff      <= tok_mem[rd_addr];
         byp_hit_ff     <= tok_wr && (add_i.user == secs_i.user);
         byp_data_ff    <= tok_wr_in;
         rsp_allowed_ff <= allowed;
      end
      if (tok_wr) begin
         tok_mem[wr_addr] <= tok_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= add_i.vld;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;

endmodule

// File: hw/rtl/per_user_token_bucket_limiter.sv
// Per-user token bucket rate limiter: pipeline with CSR block.
// Depends on ptbl_pkg, ptbl_time, ptbl_scale, ptbl_token and the assert header.
//
// Usage:
//   Request channel (req_valid / req_stall): user index and a 32-bit tick time.
//   Response channel (rsp_valid / rsp_stall): one allowed bit per request, in
//   request order. A transaction moves when valid is high and stall is low.
//   CSR channel (csr_valid / csr_ready, always ready): index 0 sets bucket
//   capacity, index 1 the refill per whole second; write only while idle.
// Timing:
//   One request per cycle is sustained while rsp_stall is low; the loops
//   that set this are the token and last-refill time read-modify-writes in
//   the last and front stages, each fed by a same-user bypass.
//   Seconds come from a reciprocal multiply, then a seconds-times-rate multiply,
//   each in a stage of its own.
// Reset:
//   All buckets are marked absent, capacity goes to 5 and rate to 1. There is
//   no clearing pass; requests are taken in the first cycle after reset.
// Backpressure:
//   While a response is held by rsp_stall the whole pipeline freezes and
//   req_stall is raised in the same cycle.
`include "per_user_token_bucket_limiter_assert.svh"

module per_user_token_bucket_limiter import ptbl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [USER_W-1:0]     req_user_index,
   input  logic [TICKS_W-1:0]    req_now_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_allowed,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TOKEN_W-1:0] capacity_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               adv;
   elap_type           elap;
   secs_type           secs;
   add_type            add;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         rate_ff     <= REFILL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY: capacity_ff <= TOKEN_W'(csr_wdata);
            CSR_REFILL:   rate_ff     <= RATE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   ptbl_time u_time (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .req_valid      (req_valid),
      .req_user_index (req_user_index),
      .req_now_ticks  (req_now_ticks),
      .elap_o         (elap)
   );

   ptbl_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .rate   (rate_ff),
      .elap_i (elap),
      .secs_o (secs),
      .add_o  (add)
   );

   ptbl_token u_token (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .capacity    (capacity_ff),
      .secs_i      (secs),
      .add_i       (add),
      .rsp_valid   (rsp_valid),
      .rsp_allowed (rsp_allowed)
   );

   `PTBL_ASSERT_NOW(a_stall_blocks_req, rsp_valid && rsp_stall, req_stall, "request taken while response held")
   `PTBL_ASSERT_NOW(a_rsp_from_pipe, $rose(rsp_valid), $past(add.vld), "response without a request in the last stage")
   `PTBL_ASSERT_NEXT(a_freeze, !adv, $stable({elap.vld, secs.vld, add.vld, rsp_valid}), "pipeline moved while frozen")

endmodule

// File: verif/per_user_token_bucket_limiter_test.sv
// Self-checking testbench for per_user_token_bucket_limiter: directed table, then random
// traffic phases under several capacity / refill settings, checked against a bucket predictor.
// Depends on ptbl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module per_user_token_bucket_limiter_test;
   import ptbl_pkg::*;

   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 12;
   localparam int MAX_GAP          = 9;
   localparam int DRAIN_CYCLES     = 8;
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 116;
   localparam int REPORT_MAX       = 10;
   localparam int HOT_USERS        = 4;
   localparam bit ALLOW            = 1'b1;
   localparam bit BLOCK            = 1'b0;

   typedef enum logic [1:0] {ROW_CSR, ROW_PREDICT, ROW_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [USER_W-1:0]     user;
      logic [TICKS_W-1:0]    now;
      logic                  known_allowed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [USER_W-1:0]     req_user_index;
   logic [TICKS_W-1:0]    req_now_ticks;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_allowed;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // expectation typed in the directed table rides along with the request
   bit req_known;
   bit req_known_allowed;
   bit req_gaps;
   bit rsp_gaps;

   // bucket predictor state
   bit                 bucket_live   [USER_COUNT];
   logic [TOKEN_W-1:0] bucket_tokens [USER_COUNT];
   logic [TICKS_W-1:0] bucket_stamp  [USER_COUNT];
   logic [TOKEN_W-1:0] cap_setting;
   logic [RATE_W-1:0]  rate_setting;

   bit pending_allowed[$];
   int fail_count;
   int quiet_cycles;

   per_user_token_bucket_limiter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_user_index (req_user_index),
      .req_now_ticks  (req_now_ticks),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_allowed    (rsp_allowed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // New buckets start full; refill by whole seconds, saturate at capacity, then take one token if any.
   function automatic bit police_request(logic [USER_W-1:0] user, logic [TICKS_W-1:0] now);
      logic [TICKS_W-1:0] elapsed;
      logic [63:0]        secs;
      logic [63:0]        level;
      bit                 granted;
      granted = BLOCK;
      if (int'(user) >= USER_COUNT)
         return BLOCK;
      if (!bucket_live[user]) begin
         bucket_live[user]   = 1'b1;
         bucket_tokens[user] = cap_setting;
         bucket_stamp[user]  = now;
      end
      elapsed = now - bucket_stamp[user];
      secs    = 64'(elapsed) / 64'(TICKS_PER_SECOND);
      if (secs != 0) begin
         level = 64'(bucket_tokens[user]) + secs * 64'(rate_setting);
         if (level > 64'(cap_setting))
            level = 64'(cap_setting);
         bucket_tokens[user] = level[TOKEN_W-1:0];
         bucket_stamp[user]  = now;
      end
      if (bucket_tokens[user] != 0) begin
         bucket_tokens[user] = bucket_tokens[user] - 1'b1;
         granted = ALLOW;
      end
      return granted;
   endfunction

   function automatic stim_row_type req_row(logic [USER_W-1:0] user, logic [TICKS_W-1:0] now);
      return '{kind: ROW_PREDICT, reg_idx: '0, reg_val: '0, user: user, now: now,
               known_allowed: BLOCK};
   endfunction

   function automatic stim_row_type known_row(logic [USER_W-1:0] user,
                                              logic [TICKS_W-1:0] now, bit allowed);
      return '{kind: ROW_KNOWN, reg_idx: '0, reg_val: '0, user: user, now: now,
               known_allowed: allowed};
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      return '{kind: ROW_CSR, reg_idx: idx, reg_val: val, user: '0, now: '0,
               known_allowed: BLOCK};
   endfunction

   // Scoreboard: predict on request transactions, compare on response transactions.
   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_allowed.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected response: allowed %0b with nothing pending", rsp_allowed);
            end else begin
               want = pending_allowed.pop_front();
               if (rsp_allowed !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("allowed mismatch at %0t: expected %0b, got %0b",
                              $realtime, want, rsp_allowed);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = police_request(req_user_index, req_now_ticks);
            pending_allowed.push_back(req_known ? req_known_allowed : want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY: cap_setting  = csr_wdata;
               CSR_REFILL:   rate_setting = csr_wdata;
               default: ;
            endcase
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: random stall before each response transaction.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = rsp_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (hold > 0) begin
            @(negedge clock) rsp_stall = 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic issue_request(logic [USER_W-1:0] user, logic [TICKS_W-1:0] now,
                                bit known, bit known_allowed);
      int gap;
      gap = req_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_user_index    = user;
      req_now_ticks     = now;
      req_known         = known;
      req_known_allowed = known_allowed;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off new requests until every response is back and the pipe is empty.
   task automatic settle_pipeline();
      @(negedge clock) req_valid = 1'b0;
      while (pending_allowed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid = 1'b0;
   endtask

   // Mostly advancing time on a few busy users; some arbitrary jumps and stray users.
   task automatic run_traffic_phase(logic [TOKEN_W-1:0] cap, logic [RATE_W-1:0] rate,
                                    bit gaps_on_req, bit gaps_on_rsp);
      logic [USER_W-1:0]  hot [HOT_USERS];
      logic [TICKS_W-1:0] stamp;
      logic [USER_W-1:0]  user;
      int                 pick;
      settle_pipeline();
      write_register(CSR_CAPACITY, cap);
      write_register(CSR_REFILL, rate);
      req_gaps = gaps_on_req;
      rsp_gaps = gaps_on_rsp;
      foreach (hot[i])
         hot[i] = USER_W'($urandom_range(0, USER_COUNT - 1));
      stamp = $urandom();
      repeat (RANDOM_PER_PHASE) begin
         pick = $urandom_range(0, 99);
         // 55..79 keeps the same tick
         if (pick < 55)
            stamp += $urandom_range(0, 300);
         else if (pick >= 95)
            stamp = $urandom();
         else if (pick >= 80)
            stamp += $urandom_range(1000, 5000);
         if ($urandom_range(0, 9) < 7)
            user = hot[$urandom_range(0, HOT_USERS - 1)];
         else
            user = USER_W'($urandom_range(0, USER_COUNT - 1));
         issue_request(user, stamp, 1'b0, BLOCK);
      end
   endtask

   initial begin
      stim_row_type directed_rows[$];
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_user_index    = '0;
      req_now_ticks     = '0;
      req_known         = 1'b0;
      req_known_allowed = BLOCK;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_gaps          = 1'b1;
      rsp_gaps          = 1'b1;
      fail_count        = 0;
      quiet_cycles      = 0;
      foreach (bucket_live[i])
         bucket_live[i] = 1'b0;
      cap_setting  = CAPACITY_RESET;
      rate_setting = REFILL_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      directed_rows = '{
         known_row(0, 0, ALLOW),               // new bucket starts full at 5
         known_row(0, 0, ALLOW),
         known_row(0, 0, ALLOW),
         known_row(0, 0, ALLOW),
         known_row(0, 0, ALLOW),
         known_row(0, 0, BLOCK),               // drained
         known_row(0, 999, BLOCK),             // just short of a second
         known_row(0, 1000, ALLOW),            // one second, one token
         known_row(0, 0, ALLOW),               // time runs backwards: huge elapsed, refilled
         known_row(63, 32'hFFFF_FFFF, ALLOW),
         req_row(63, 32'h0000_0000),           // wrap by one tick, no refill
         csr_row(CSR_CAPACITY, 16'h0000),
         known_row(1, 32'd12345, BLOCK),       // zero capacity: new bucket empty
         req_row(0, 32'd1000),
         csr_row(CSR_CAPACITY, 16'hFFFF),
         csr_row(CSR_REFILL, 16'hFFFF),
         known_row(2, 0, ALLOW),
         req_row(2, 32'hFFFF_FFFF),            // widest seconds times widest rate
         csr_row(CSR_CAPACITY, 16'h0001),
         req_row(2, 32'hFFFF_FFFF),            // above lowered capacity, no refill yet
         req_row(2, 32'hFFFF_FFFF),
         req_row(2, 32'h0000_0BFF),            // refill clamps to the new capacity
         req_row(2, 32'h0000_0BFF),
         csr_row(CSR_REFILL, 16'h0000),
         req_row(63, 32'h8000_0000),
         req_row(42, 32'h5555_AAAA)
      };

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            settle_pipeline();
            write_register(directed_rows[k].reg_idx, directed_rows[k].reg_val);
         end else begin
            issue_request(directed_rows[k].user, directed_rows[k].now,
                          directed_rows[k].kind == ROW_KNOWN, directed_rows[k].known_allowed);
         end
      end

      run_traffic_phase(CAPACITY_RESET, REFILL_RESET, 1'b1, 1'b1);
      run_traffic_phase(16'h0000, 16'hFFFF, 1'b1, 1'b0);
      run_traffic_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      run_traffic_phase(16'd3, 16'h0000, 1'b0, 1'b1);
      run_traffic_phase(16'd1, 16'd1, 1'b1, 1'b1);
      run_traffic_phase(16'($urandom_range(1, 40)), 16'($urandom_range(0, 10)), 1'b1, 1'b1);
      run_traffic_phase(16'hFFFF, 16'd1, 1'b0, 1'b0);
      run_traffic_phase(16'($urandom()), 16'($urandom()), 1'b1, 1'b1);

      settle_pipeline();
      if (fail_count == 0 && pending_allowed.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
